FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with reset disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge while out of reset.
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every rising clk edge while out of reset.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

FILE: sv/lbcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LED blink code sequencer package
// Operation codes, item and status types, and the fixed blink pattern ROM.
// ---------------------------------------------------------------------------
package lbcs_pkg;

	// Number of entries held in the pattern ROM.
	localparam int ROM_DEPTH = 10;
	// Default number of status codes that have a pattern.
	localparam int PATTERN_COUNT_DEF = 10;

	// Operation codes carried in the operation field.
	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_FLASH  = 2'd1,
		OP_STATUS = 2'd2
	} op_t;

	// One accepted input word.
	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  status_code;
		logic        retrigger;
		logic [7:0]  flash_count;
		logic [15:0] on_time;
		logic [15:0] off_time;
	} item_t;

	// Visible state after a word has been processed.
	typedef struct packed {
		logic       lit;
		logic       running;
		logic [3:0] status;
	} status_t;

	// One blink pattern.
	typedef struct packed {
		logic [7:0]  count;
		logic [15:0] on_ms;
		logic [15:0] off_ms;
		logic        loops;
	} pattern_t;

	// Fixed pattern ROM; codes without an entry read as an empty pattern.
	function automatic pattern_t pattern_lookup(input logic [3:0] code);
		pattern_t p;
		p = '0;
		case (code)
			4'd0: p = '{8'd5, 16'd120, 16'd120, 1'b0};
			4'd1: p = '{8'd3, 16'd200, 16'd200, 1'b0};
			4'd2: p = '{8'd1, 16'd200, 16'd600, 1'b1};
			4'd3: p = '{8'd2, 16'd90, 16'd160, 1'b0};
			4'd4: p = '{8'd3, 16'd90, 16'd90, 1'b0};
			4'd5: p = '{8'd3, 16'd90, 16'd250, 1'b0};
			4'd6: p = '{8'd5, 16'd70, 16'd70, 1'b0};
			4'd7: p = '{8'd4, 16'd100, 16'd100, 1'b0};
			4'd8: p = '{8'd2, 16'd200, 16'd600, 1'b1};
			4'd9: p = '{8'd1, 16'd1000, 16'd1000, 1'b1};
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: sv/lbcs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LED blink code sequencer core
// Holds the blink state and applies one word per fire strobe.
// ---------------------------------------------------------------------------
module lbcs_core import lbcs_pkg::*; #(
	parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output status_t state
);

	logic        lit_q, running_q, looping_q;
	logic [7:0]  target_q, done_q;
	logic [15:0] elapsed_q, lit_len_q, dark_len_q;
	logic [3:0]  status_q;

	logic        lit_d, running_d, looping_d;
	logic [7:0]  target_d, done_d;
	logic [15:0] elapsed_d, lit_len_d, dark_len_d;
	logic [3:0]  status_d;

	logic [15:0] elapsed_inc;
	logic        all_shown;
	logic        code_known;
	pattern_t    pat;

	// Saturating millisecond count and flash completion check.
	assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
	assign all_shown   = (done_q >= target_q);

	// Pattern lookup; codes at or past the pattern count have no entry.
	assign pat        = pattern_lookup(item.status_code);
	assign code_known = ({1'b0, item.status_code} < 5'(PATTERN_COUNT)) &&
		({1'b0, item.status_code} < 5'(ROM_DEPTH)) && (pat.count != 8'd0);

	// Next-state logic for one word.
	always_comb begin
		lit_d      = lit_q;
		running_d  = running_q;
		looping_d  = looping_q;
		target_d   = target_q;
		done_d     = done_q;
		elapsed_d  = elapsed_q;
		lit_len_d  = lit_len_q;
		dark_len_d = dark_len_q;
		status_d   = status_q;
		case (item.operation)
			OP_TICK: begin
				if (running_q) begin
					elapsed_d = elapsed_inc;
					if (lit_q) begin
						if (elapsed_inc >= lit_len_q) begin
							lit_d     = 1'b0;
							elapsed_d = '0;
							if (all_shown) begin
								if (looping_q) done_d = '0;
								else running_d = 1'b0;
							end
						end
					end else if (all_shown && !looping_q) begin
						running_d = 1'b0;
					end else if (elapsed_inc >= dark_len_q) begin
						lit_d     = 1'b1;
						elapsed_d = '0;
						done_d    = done_q + 8'd1;
					end
				end
			end
			OP_FLASH: begin
				if (item.flash_count != 8'd0) begin
					target_d   = item.flash_count;
					lit_len_d  = item.on_time;
					dark_len_d = item.off_time;
					done_d     = 8'd1;
					lit_d      = 1'b1;
					running_d  = 1'b1;
					looping_d  = 1'b0;
					elapsed_d  = '0;
				end
			end
			OP_STATUS: begin
				status_d = item.status_code;
				if (item.retrigger) begin
					if (code_known) begin
						target_d   = pat.count;
						lit_len_d  = pat.on_ms;
						dark_len_d = pat.off_ms;
						done_d     = 8'd1;
						lit_d      = 1'b1;
						running_d  = 1'b1;
						looping_d  = pat.loops;
						elapsed_d  = '0;
					end else begin
						running_d = 1'b0;
						looping_d = 1'b0;
						lit_d     = 1'b0;
					end
				end
			end
			default: begin
				lit_d = lit_q;
			end
		endcase
	end

	// State registers, updated once per processed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q      <= 1'b0;
			running_q  <= 1'b0;
			looping_q  <= 1'b0;
			target_q   <= '0;
			done_q     <= '0;
			elapsed_q  <= '0;
			lit_len_q  <= '0;
			dark_len_q <= '0;
			status_q   <= '0;
		end else if (fire) begin
			lit_q      <= lit_d;
			running_q  <= running_d;
			looping_q  <= looping_d;
			target_q   <= target_d;
			done_q     <= done_d;
			elapsed_q  <= elapsed_d;
			lit_len_q  <= lit_len_d;
			dark_len_q <= dark_len_d;
			status_q   <= status_d;
		end
	end

	assign state = '{lit: lit_q, running: running_q, status: status_q};

endmodule
`default_nettype wire

FILE: sv/led_blink_code_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LED blink code sequencer
// Drives a status LED with blink codes from ticks, flash commands and
// status sets.
// ---------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid/in_ready: a one-millisecond tick, a direct
//   flash command, or a status set that may start a pattern from the ROM.
//   Every input word yields exactly one output word on out_valid/out_ready,
//   giving the LED level, the busy flag and the recorded status after it.
//   A word passes the input register and then the blink state, which doubles
//   as the result register. One word per cycle is sustained while out_ready
//   is high; the state update is a single pass of compares and increments.
//   When the receiver stalls, the result holds and one more word may wait in
//   the input register; in_ready drops only when both are full.
//   Reset (arst_n low) clears the LED, stops blinking, sets status 0 and
//   empties both registers.
// ---------------------------------------------------------------------------
module led_blink_code_sequencer import lbcs_pkg::*; #(
	parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [3:0]  status_code,
	input  logic        retrigger,
	input  logic [7:0]  flash_count,
	input  logic [15:0] on_time,
	input  logic [15:0] off_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        led_level,
	output logic        busy_res,
	output logic [3:0]  present_status
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	logic    advance;
	status_t state;

	// A word leaves the input register when the result slot is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{operation: operation, status_code: status_code,
				retrigger: retrigger, flash_count: flash_count,
				on_time: on_time, off_time: off_time};
		end
	end

	// Result valid; the result payload is the core state, which only moves on advance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	lbcs_core #(
		.PATTERN_COUNT(PATTERN_COUNT)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.state (state)
	);

	assign out_valid      = out_valid_q;
	assign led_level      = state.lit;
	assign busy_res       = state.running;
	assign present_status = state.status;

endmodule
`default_nettype wire

FILE: sv/lbcs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// LED blink code sequencer checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lbcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        led_level,
	input logic        busy_res,
	input logic [3:0]  present_status
);

	// A lit LED only ever belongs to a running sequence.
	`ASSERT_IMPL(a_lit_busy, out_valid && led_level, busy_res, "LED lit while idle")

	// With no result pending the block always takes a word.
	`ASSERT_IMPL(a_empty_ready, !out_valid, in_ready, "in_ready low with empty output")

	// A draining result always makes room for a new word.
	`ASSERT_IMPL(a_drain_ready, out_ready, in_ready, "in_ready low while output drains")

	// A stalled result word holds its value.
	`ASSERT_CLKD(a_stall_hold, out_valid && !out_ready |=> out_valid && $stable(led_level) && $stable(busy_res) && $stable(present_status), "stalled result word changed")

	// While a word is offered, the block gives a defined answer on in_ready.
	`ASSERT_IMPL(a_ready_known, in_valid, !$isunknown(in_ready), "in_ready unknown while a word is offered")

endmodule

bind led_blink_code_sequencer lbcs_checker u_lbcs_checker (.*);
`default_nettype wire

FILE: dv/led_blink_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED blink code sequencer checker
// Watches both channels of the sequencer, keeps its own blink state machine
// in step with every accepted input word, and compares each result word
// field by field against the oldest predicted LED state.
// ---------------------------------------------------------------------------
module led_blink_checker import lbcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [3:0]  status_code,
	input  logic        retrigger,
	input  logic [7:0]  flash_count,
	input  logic [15:0] on_time,
	input  logic [15:0] off_time,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        led_level,
	input  logic        busy_res,
	input  logic [3:0]  present_status,
	output int          errors,
	output int          pending,
	output int          checked
);

	// Status codes below this bound have a blink pattern.
	localparam int KNOWN_CODES = 10;

	// Predicted blinker state.
	logic        led_on;
	logic        seq_active;
	logic        seq_loops;
	logic [7:0]  flash_target;
	logic [7:0]  flash_shown;
	logic [15:0] ms_count;
	logic [15:0] on_len;
	logic [15:0] off_len;
	logic [3:0]  status_rec;

	pattern_t code_table [0:KNOWN_CODES-1];
	status_t  expected_led_q [$];
	item_t    word;
	status_t  want;
	int       mismatch_total;
	int       result_total;

	assign word = {operation, status_code, retrigger, flash_count, on_time, off_time};

	// Blink patterns per status code: count, lit ms, dark ms, repeats.
	initial begin
		code_table[0] = '{8'd5, 16'd120, 16'd120, 1'b0};
		code_table[1] = '{8'd3, 16'd200, 16'd200, 1'b0};
		code_table[2] = '{8'd1, 16'd200, 16'd600, 1'b1};
		code_table[3] = '{8'd2, 16'd90, 16'd160, 1'b0};
		code_table[4] = '{8'd3, 16'd90, 16'd90, 1'b0};
		code_table[5] = '{8'd3, 16'd90, 16'd250, 1'b0};
		code_table[6] = '{8'd5, 16'd70, 16'd70, 1'b0};
		code_table[7] = '{8'd4, 16'd100, 16'd100, 1'b0};
		code_table[8] = '{8'd2, 16'd200, 16'd600, 1'b1};
		code_table[9] = '{8'd1, 16'd1000, 16'd1000, 1'b1};
	end

	task automatic report_mismatch(input string field, input int got, input int exp_val);
		$display("MISMATCH result %0d %s: got %0d expected %0d", result_total, field, got,
			exp_val);
		mismatch_total++;
	endtask

	// A new sequence starts lit with its first flash; a zero count is ignored.
	task automatic begin_flashes(input logic [7:0] cnt, input logic [15:0] lit_ms,
			input logic [15:0] dark_ms);
		if (cnt != 8'd0) begin
			flash_target = cnt;
			on_len       = lit_ms;
			off_len      = dark_ms;
			flash_shown  = 8'd1;
			led_on       = 1'b1;
			seq_active   = 1'b1;
			seq_loops    = 1'b0;
			ms_count     = 16'd0;
		end
	endtask

	// Advances the predicted state by one accepted input word.
	task automatic apply_word(input item_t w);
		case (w.operation)
			OP_TICK: begin
				if (seq_active) begin
					if (ms_count != 16'hFFFF)
						ms_count++;
					if (led_on) begin
						if (ms_count >= on_len) begin
							led_on   = 1'b0;
							ms_count = 16'd0;
							if (flash_shown >= flash_target) begin
								if (seq_loops)
									flash_shown = 8'd0;
								else
									seq_active = 1'b0;
							end
						end
					end else if (flash_shown >= flash_target && !seq_loops) begin
						// The last dark gap of a one-shot sequence ends it.
						seq_active = 1'b0;
					end else if (ms_count >= off_len) begin
						led_on   = 1'b1;
						ms_count = 16'd0;
						flash_shown++;
					end
				end
			end
			OP_FLASH: begin_flashes(w.flash_count, w.on_time, w.off_time);
			OP_STATUS: begin
				if (!(w.status_code == status_rec && !w.retrigger)) begin
					status_rec = w.status_code;
					if (w.retrigger) begin
						if (w.status_code < KNOWN_CODES) begin
							begin_flashes(code_table[w.status_code].count,
								code_table[w.status_code].on_ms,
								code_table[w.status_code].off_ms);
							seq_loops = code_table[w.status_code].loops;
						end else begin
							// An unknown code darkens the LED and stops blinking.
							seq_active = 1'b0;
							seq_loops  = 1'b0;
							led_on     = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// Predict on every accepted input word, check every accepted result word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_on         = 1'b0;
			seq_active     = 1'b0;
			seq_loops      = 1'b0;
			flash_target   = 8'd0;
			flash_shown    = 8'd0;
			ms_count       = 16'd0;
			on_len         = 16'd0;
			off_len        = 16'd0;
			status_rec     = 4'd0;
			mismatch_total = 0;
			result_total   = 0;
			expected_led_q.delete();
			errors  <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_word(word);
				expected_led_q.push_back(status_t'{led_on, seq_active, status_rec});
			end
			if (out_valid && out_ready) begin
				if (expected_led_q.size() == 0) begin
					$display("MISMATCH result %0d arrived with no word outstanding",
						result_total);
					mismatch_total++;
				end else begin
					want = expected_led_q.pop_front();
					if (led_level !== want.lit)
						report_mismatch("led_level", led_level, want.lit);
					if (busy_res !== want.running)
						report_mismatch("busy_res", busy_res, want.running);
					if (present_status !== want.status)
						report_mismatch("present_status", present_status, want.status);
				end
				result_total++;
			end
			errors  <= mismatch_total;
			pending <= expected_led_q.size();
			checked <= result_total;
		end
	end

endmodule

FILE: dv/tb_led_blink_code_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LED blink code sequencer testbench
// Drives ticks, flash commands and status sets with random gaps and output
// stalls; a checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_led_blink_code_sequencer;
	import lbcs_pkg::*;

	// Operation code with no function in the block.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 800;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = OP_TICK;
	logic [3:0]  status_code = 4'd0;
	logic        retrigger = 1'b0;
	logic [7:0]  flash_count = 8'd0;
	logic [15:0] on_time = 16'd0;
	logic [15:0] off_time = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        led_level;
	logic        busy_res;
	logic [3:0]  present_status;
	int          fail_count;
	int          words_pending;
	int          results_checked;
	int          words_sent = 0;
	logic        no_gaps = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	led_blink_code_sequencer u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .status_code(status_code), .retrigger(retrigger),
		.flash_count(flash_count), .on_time(on_time), .off_time(off_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.led_level(led_level), .busy_res(busy_res), .present_status(present_status)
	);

	led_blink_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .status_code(status_code), .retrigger(retrigger),
		.flash_count(flash_count), .on_time(on_time), .off_time(off_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.led_level(led_level), .busy_res(busy_res), .present_status(present_status),
		.errors(fail_count), .pending(words_pending), .checked(results_checked)
	);

	// The receiver stalls at random, with a chance of about 11 in a hundred.
	always @(posedge clk) begin
		out_ready <= no_gaps || ($urandom_range(0, 99) >= 11);
	end

	// A word with every field random; callers override what matters.
	function automatic item_t random_word(input logic [1:0] op);
		item_t       w;
		logic [63:0] r;
		r = {$urandom, $urandom};
		w = r[$bits(item_t)-1:0];
		w.operation = op;
		return w;
	endfunction

	// Presents one word after an optional idle gap and holds it until taken.
	task automatic send_word(input item_t w);
		while (!no_gaps && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= w.operation;
		status_code <= w.status_code;
		retrigger   <= w.retrigger;
		flash_count <= w.flash_count;
		on_time     <= w.on_time;
		off_time    <= w.off_time;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	task automatic send_flash(input logic [7:0] cnt, input logic [15:0] lit_ms,
			input logic [15:0] dark_ms);
		item_t w;
		w = random_word(OP_FLASH);
		w.flash_count = cnt;
		w.on_time     = lit_ms;
		w.off_time    = dark_ms;
		send_word(w);
	endtask

	task automatic send_status(input logic [3:0] code, input logic again);
		item_t w;
		w = random_word(OP_STATUS);
		w.status_code = code;
		w.retrigger   = again;
		send_word(w);
	endtask

	// A run of millisecond ticks; with mixed set, status records and unused
	// words are sprinkled in without disturbing the sequence.
	task automatic run_ticks(input int n, input logic mixed);
		for (int i = 0; i < n; i++) begin
			if (mixed && $urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1))
					send_status(4'($urandom_range(0, 15)), 1'b0);
				else
					send_word(random_word(OP_UNUSED));
			end
			send_word(random_word(OP_TICK));
		end
	endtask

	// Directed cases, then random sequences, then drain and verdict.
	initial begin
		int start_count;
		int pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle behavior: ticks, unused words, repeated and unknown status.
		send_word(random_word(OP_TICK));
		send_word(random_word(OP_UNUSED));
		send_status(4'd0, 1'b0);
		send_status(4'd12, 1'b0);
		send_flash(8'd0, 16'd5, 16'd5);
		// Zero lit and dark times, then a short three-flash sequence.
		send_flash(8'd1, 16'd0, 16'd0);
		run_ticks(3, 1'b0);
		send_flash(8'd3, 16'd1, 16'd2);
		run_ticks(12, 1'b0);
		// Largest count and times, cut short by an unknown status.
		send_flash(8'd255, 16'hFFFF, 16'hFFFF);
		run_ticks(3, 1'b0);
		send_status(4'd15, 1'b1);
		run_ticks(2, 1'b0);
		// A repeating pattern through one full loop, restarted on the same code.
		send_status(4'd2, 1'b1);
		run_ticks(810, 1'b0);
		send_status(4'd2, 1'b1);
		run_ticks(5, 1'b0);
		send_status(4'd10, 1'b1);
		send_status(4'd7, 1'b0);
		send_status(4'd3, 1'b1);
		run_ticks(350, 1'b0);

		// Random part: mostly short sequences with ticks, some noise.
		start_count = words_sent;
		while (words_sent - start_count < RANDOM_WORDS) begin
			no_gaps = (words_sent - start_count) inside {[300:599]};
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				if ($urandom_range(0, 7) == 0)
					send_flash(8'($urandom), 16'($urandom_range(0, 6)),
						16'($urandom_range(0, 6)));
				else
					send_flash(8'($urandom_range(1, 4)), 16'($urandom_range(0, 6)),
						16'($urandom_range(0, 6)));
				run_ticks($urandom_range(1, 40), 1'b1);
			end else if (pick < 65) begin
				send_status(4'($urandom_range(0, 15)), 1'b1);
				if ($urandom_range(0, 19) == 0)
					run_ticks($urandom_range(200, 900), 1'b1);
				else
					run_ticks($urandom_range(1, 40), 1'b1);
			end else if (pick < 80) begin
				send_status(4'($urandom_range(0, 15)), 1'b0);
			end else if (pick < 90) begin
				send_word(random_word(OP_FLASH));
			end else if (pick < 95) begin
				send_word(random_word(OP_UNUSED));
			end else begin
				run_ticks($urandom_range(1, 20), 1'b0);
			end
		end
		no_gaps = 1'b0;
		in_valid <= 1'b0;

		// Let the last accepted word reach the pending count before waiting.
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d words: directed edge cases, a looping pattern, unknown codes",
			words_sent);
		$display("and random flash sequences; %0d result words checked.",
			results_checked);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#5_000_000;
		$display("Timeout with %0d words still outstanding", words_pending);
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/lbcs_pkg.sv
sv/lbcs_core.sv
sv/led_blink_code_sequencer.sv
sv/lbcs_checker.sv
dv/led_blink_checker.sv
dv/tb_led_blink_code_sequencer.sv
